### sv/psrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psrp_pkg
// Shared constants and codes for the PC sample region profiler.
// ----------------------------------------------------------------------------
package psrp_pkg;
    localparam int MAX_REGIONS_DEF = 16;
    localparam int ADDR_BITS_DEF   = 32;
    localparam int RESULT_CAP      = 16;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_REPORT = 2'd3;

    localparam logic CFG_ENABLED     = 1'b0;
    localparam logic CFG_NUM_REGIONS = 1'b1;
endpackage
`default_nettype wire

### sv/psrp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psrp_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module psrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### sv/pc_sample_region_profiler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pc_sample_region_profiler
// Region table with per-region hit counters and a ranked report.
// ----------------------------------------------------------------------------
// A load or a disabled sample completes as it is accepted. A sample walks the
// regions, reading then comparing each, and stops at the first that holds the
// address or, on a miss, after all in use. A clear walks the regions in use. A
// report on two or more regions sorts them and emits words held until taken.
// One item is processed at a time. Reset clears totals and the enable, resets
// the region count, then a pass zeroes bound and count memories, readies low.
// ----------------------------------------------------------------------------
module pc_sample_region_profiler #(
    parameter int MAX_REGIONS = psrp_pkg::MAX_REGIONS_DEF,
    parameter int ADDR_BITS   = psrp_pkg::ADDR_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [3:0]  region_index,
    input  wire logic [31:0] range_start,
    input  wire logic [31:0] range_end,
    input  wire logic [31:0] pc,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             entry_valid,
    output logic [3:0]       ranked_region,
    output logic [31:0]      ranked_count,
    output logic [31:0]      sample_total,
    output logic [31:0]      lost_total,
    output logic [31:0]      lost_address,
    output logic             last
);
    localparam int IW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW    = $clog2(MAX_REGIONS + 1);
    localparam int SLOTS = 1 << IW;

    typedef enum logic [7:0] {
        S_WIPE = 8'b00000001,
        S_IDLE = 8'b00000010,
        S_WALK = 8'b00000100,
        S_CLR  = 8'b00001000,
        S_SEL  = 8'b00010000,
        S_CMP  = 8'b00100000,
        S_EMIT = 8'b01000000,
        S_OUT  = 8'b10000000
    } state_t;

    state_t        state_reg;
    logic          enabled_reg;
    logic [4:0]    num_reg;
    logic [31:0]   tick_reg, miss_reg, maddr_reg, pc_reg;
    logic [CW-1:0] i_reg, j_reg, n_reg;
    logic          phase_reg;

    // The rank order is small and lives in registers. During the sort cur_reg
    // holds the region currently at rank i and best_reg its count.
    logic [IW-1:0] rank_reg [SLOTS];
    logic [IW-1:0] cur_reg;
    logic [31:0]   best_reg;

    logic          out_valid_reg;
    logic          entry_valid_reg;
    logic [3:0]    ranked_region_reg;
    logic [31:0]   ranked_count_reg;
    logic          last_reg;

    // Bound memory holds {high, low} per region; count memory holds the hits.
    logic          bnd_we;
    logic [IW-1:0] bnd_addr;
    logic [63:0]   bnd_wdata, bnd_rdata;
    logic          cnt_we;
    logic [IW-1:0] cnt_addr;
    logic [31:0]   cnt_wdata, cnt_rdata;

    logic [CW-1:0] n_use;
    logic [31:0]   amask;
    logic          item_take;
    logic          load_ok;
    logic          in_range;

    psrp_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_bounds (
        .clk(clk), .we(bnd_we), .addr(bnd_addr), .wdata(bnd_wdata), .rdata(bnd_rdata)
    );

    psrp_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_counts (
        .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
    );

    // Regions in use saturate at the table size.
    assign n_use = (32'(num_reg) > 32'(MAX_REGIONS)) ? CW'(MAX_REGIONS) : CW'(num_reg);

    assign amask = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF
                                     : 32'((64'd1 << ADDR_BITS) - 64'd1);

    // A configuration write takes priority over an input word in the same
    // cycle, so the two never land together.
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign item_take = in_valid && in_ready;
    assign load_ok   = (32'(region_index) < 32'(MAX_REGIONS));

    // Bounds of region i_reg arrive in the cycle after the address is presented.
    assign in_range = (pc_reg >= bnd_rdata[31:0]) && (pc_reg <= bnd_rdata[63:32]);

    always_comb
    begin
        bnd_we    = 1'b0;
        bnd_addr  = i_reg[IW-1:0];
        bnd_wdata = {range_end & amask, range_start & amask};
        cnt_we    = 1'b0;
        cnt_addr  = i_reg[IW-1:0];
        cnt_wdata = '0;
        case (state_reg)
            S_WIPE:
            begin
                bnd_we    = 1'b1;
                bnd_wdata = '0;
                cnt_we    = 1'b1;
            end
            S_IDLE:
            begin
                // A load writes its bounds at the accepting edge.
                bnd_addr = IW'(region_index);
                bnd_we   = item_take && (mode == psrp_pkg::MODE_LOAD) && load_ok;
            end
            S_WALK:
            begin
                // The count of region i is read alongside its bounds, so a
                // hit writes back the incremented count in the compare cycle.
                cnt_we    = phase_reg && in_range;
                cnt_wdata = cnt_rdata + 32'd1;
            end
            S_CLR:
            begin
                cnt_we = (i_reg != n_reg);
            end
            S_SEL:
            begin
                cnt_addr = rank_reg[i_reg[IW-1:0]];
            end
            S_CMP:
            begin
                cnt_addr = rank_reg[j_reg[IW-1:0]];
            end
            S_EMIT:
            begin
                cnt_addr = rank_reg[i_reg[IW-1:0]];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_WIPE;
            enabled_reg       <= 1'b0;
            num_reg           <= 5'd16;
            tick_reg          <= '0;
            miss_reg          <= '0;
            maddr_reg         <= '0;
            pc_reg            <= '0;
            i_reg             <= '0;
            j_reg             <= '0;
            n_reg             <= '0;
            phase_reg         <= 1'b0;
            cur_reg           <= '0;
            best_reg          <= '0;
            out_valid_reg     <= 1'b0;
            entry_valid_reg   <= 1'b0;
            ranked_region_reg <= '0;
            ranked_count_reg  <= '0;
            last_reg          <= 1'b0;
            for (int k = 0; k < SLOTS; k++)
            begin
                rank_reg[k] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_WIPE:
                begin
                    if (i_reg == CW'(MAX_REGIONS - 1))
                    begin
                        i_reg     <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                        i_reg <= i_reg + CW'(1);
                end
                S_IDLE:
                begin
                    if (cfg_valid && cfg_ready)
                    begin
                        if (cfg_index == psrp_pkg::CFG_ENABLED)
                            enabled_reg <= cfg_data[0];
                        else
                            num_reg <= cfg_data;
                    end
                    if (item_take)
                    begin
                        n_reg     <= n_use;
                        i_reg     <= '0;
                        phase_reg <= 1'b0;
                        case (mode)
                            psrp_pkg::MODE_LOAD:
                            begin
                                // The bound memory port takes the write.
                            end
                            psrp_pkg::MODE_SAMPLE:
                            begin
                                if (enabled_reg)
                                begin
                                    tick_reg  <= tick_reg + 32'd1;
                                    pc_reg    <= pc & amask;
                                    state_reg <= S_WALK;
                                end
                            end
                            psrp_pkg::MODE_CLEAR:
                            begin
                                state_reg <= S_CLR;
                            end
                            psrp_pkg::MODE_REPORT:
                            begin
                                for (int k = 0; k < SLOTS; k++)
                                begin
                                    rank_reg[k] <= IW'(k);
                                end
                                if (n_use == '0)
                                begin
                                    // No regions in use: one empty last word.
                                    entry_valid_reg   <= 1'b0;
                                    ranked_region_reg <= '0;
                                    ranked_count_reg  <= '0;
                                    last_reg          <= 1'b1;
                                    out_valid_reg     <= 1'b1;
                                    state_reg         <= S_OUT;
                                end
                                else if (n_use == CW'(1))
                                    state_reg <= S_EMIT;
                                else
                                    state_reg <= S_SEL;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    // Phase 0 presents region i to both memories, phase 1
                    // compares. The first region holding the address wins.
                    if (!phase_reg)
                    begin
                        if (i_reg == n_reg)
                        begin
                            miss_reg  <= miss_reg + 32'd1;
                            maddr_reg <= pc_reg;
                            state_reg <= S_IDLE;
                        end
                        else
                            phase_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        if (in_range)
                            state_reg <= S_IDLE;
                        else
                            i_reg <= i_reg + CW'(1);
                    end
                end
                S_CLR:
                begin
                    if (i_reg == n_reg)
                        state_reg <= S_IDLE;
                    else
                        i_reg <= i_reg + CW'(1);
                end
                S_SEL:
                begin
                    // Fetch the count of the region now at rank i.
                    if (!phase_reg)
                        phase_reg <= 1'b1;
                    else
                    begin
                        phase_reg <= 1'b0;
                        best_reg  <= cnt_rdata;
                        cur_reg   <= rank_reg[i_reg[IW-1:0]];
                        j_reg     <= i_reg + CW'(1);
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    // Exchange sort: rank j takes the region at rank i when
                    // its count is strictly larger, and the two trade places.
                    if (!phase_reg)
                    begin
                        if (j_reg == n_reg)
                        begin
                            rank_reg[i_reg[IW-1:0]] <= cur_reg;
                            if (i_reg + CW'(2) >= n_reg)
                            begin
                                i_reg     <= '0;
                                state_reg <= S_EMIT;
                            end
                            else
                            begin
                                i_reg     <= i_reg + CW'(1);
                                state_reg <= S_SEL;
                            end
                        end
                        else
                            phase_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        if (best_reg < cnt_rdata)
                        begin
                            rank_reg[j_reg[IW-1:0]] <= cur_reg;
                            cur_reg  <= rank_reg[j_reg[IW-1:0]];
                            best_reg <= cnt_rdata;
                        end
                        j_reg <= j_reg + CW'(1);
                    end
                end
                S_EMIT:
                begin
                    if (!phase_reg)
                        phase_reg <= 1'b1;
                    else
                    begin
                        phase_reg         <= 1'b0;
                        entry_valid_reg   <= 1'b1;
                        ranked_region_reg <= 4'(rank_reg[i_reg[IW-1:0]]);
                        ranked_count_reg  <= cnt_rdata;
                        last_reg          <= (i_reg + CW'(1) == n_reg) ||
                                             (32'(i_reg) + 32'd1 ==
                                              32'(psrp_pkg::RESULT_CAP));
                        out_valid_reg     <= 1'b1;
                        state_reg         <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            i_reg     <= i_reg + CW'(1);
                            state_reg <= S_EMIT;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign entry_valid   = entry_valid_reg;
    assign ranked_region = ranked_region_reg;
    assign ranked_count  = ranked_count_reg;
    assign last          = last_reg;
    assign sample_total  = tick_reg;
    assign lost_total    = miss_reg;
    assign lost_address  = maddr_reg;

    // A result word is only presented while waiting in the output state.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> state_reg == S_OUT)
        else $error("result word outside output state");
    // No new item is taken while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input ready during report");
    // The walk index never passes the number of regions in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK || state_reg == S_CLR) |-> i_reg <= n_reg)
        else $error("walk index overrun");
    // A stalled result word holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
        $stable({entry_valid, ranked_region, ranked_count, sample_total,
                 lost_total, lost_address, last}))
        else $error("result word changed while stalled");
    // The state register always holds exactly one state.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register not one-hot");
endmodule
`default_nettype wire
